@@ rtl/core/utf8d_pkg.sv @@
// utf8d_pkg: shared types, constants and byte classification for the utf-8 stream decoder
// no dependencies
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int CP_W       = 31;
	localparam int CNT_W      = 3;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;
	localparam int USER_W     = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] MASK_ASCII = 8'h80;
	localparam logic [7:0] MASK_L6    = 8'hfe;
	localparam logic [7:0] MASK_L5    = 8'hfc;
	localparam logic [7:0] MASK_L4    = 8'hf8;
	localparam logic [7:0] MASK_L3    = 8'hf0;
	localparam logic [7:0] MASK_L2    = 8'he0;
	localparam logic [7:0] MASK_CONT  = 8'hc0;
	localparam logic [7:0] LEAD_L6    = 8'hfc;
	localparam logic [7:0] LEAD_L5    = 8'hf8;
	localparam logic [7:0] LEAD_L4    = 8'hf0;
	localparam logic [7:0] LEAD_L3    = 8'he0;
	localparam logic [7:0] LEAD_L2    = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [5:0] CONT_BITS  = 6'h3f;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_CUT_NC  = 3'd1,
		ST_CUT_END = 3'd2,
		ST_STRAY   = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		K_ASCII   = 2'd0,
		K_LEAD    = 2'd1,
		K_CONT    = 2'd2,
		K_INVALID = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] left;
		logic [4:0]       payload;
	} class_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] bytes_used;
		status_t          status;
		logic             run_last;
	} res_t;

	// one queue word: the results caused by one input byte
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} entry_t;

	function automatic class_t classify(input logic [7:0] b);
		class_t c;
		c.kind    = K_LEAD;
		c.left    = '0;
		c.payload = '0;
		priority if ((b & MASK_ASCII) == 8'h00) begin
			c.kind = K_ASCII;
		end else if ((b & MASK_L6) == LEAD_L6) begin
			c.left = 3'd5; c.payload = {4'b0, b[0]};
		end else if ((b & MASK_L5) == LEAD_L5) begin
			c.left = 3'd4; c.payload = {3'b0, b[1:0]};
		end else if ((b & MASK_L4) == LEAD_L4) begin
			c.left = 3'd3; c.payload = {2'b0, b[2:0]};
		end else if ((b & MASK_L3) == LEAD_L3) begin
			c.left = 3'd2; c.payload = {1'b0, b[3:0]};
		end else if ((b & MASK_L2) == LEAD_L2) begin
			c.left = 3'd1; c.payload = b[4:0];
		end else if ((b & MASK_CONT) == CONT_TAG) begin
			c.kind = K_CONT;
		end else begin
			c.kind = K_INVALID;
		end
		return c;
	endfunction

endpackage

@@ rtl/core/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level of the byte-serial utf-8 decoder with legacy 5/6-byte forms
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
`timescale 1ns / 1ps

// One byte enters per cycle on the slave side and one result leaves per cycle on the master
// side, while tready and m_tready are high. The front keeps the open sequence in registers and
// decides in the cycle it takes a byte; its results go as one word into a queue of QUEUE_DEPTH
// words, and the back drains it through a single output register, so a result passes through
// the queue and then the output register before it is offered. A byte that closes a cut sequence
// and also yields a value of its own gives two results; the queue holds later words meanwhile.
// Bytes that only extend a sequence give no result. tready falls only when the queue is full.

module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [utf8d_pkg::IN_DATA_W-1:0]     s_tdata,  // byte_in
	input  logic                                s_tlast,  // buffer_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [utf8d_pkg::OUT_DATA_W-1:0]    m_tdata,  // code_point, bytes_used, zero fill
	output logic [utf8d_pkg::USER_W-1:0]        m_tuser,  // status
	output logic                                m_tlast   // run_last
);
	import utf8d_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   full;
	logic   pop;
	logic   head_valid;
	entry_t head;
	res_t   out_res;

	utf8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.byte_in    (s_tdata),
		.buffer_end (s_tlast),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	utf8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	assign m_tdata = {{(OUT_DATA_W - CP_W - CNT_W){1'b0}}, out_res.bytes_used, out_res.code_point};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.run_last;

endmodule

@@ rtl/core/utf8d_front.sv @@
// utf8d_front: accepts bytes, tracks the open sequence and forms the results of each byte
// depends on utf8d_pkg; feeds utf8d_queue
`timescale 1ns / 1ps

module utf8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        byte_in,
	input  logic              buffer_end,
	output logic              push,
	output utf8d_pkg::entry_t push_entry,
	input  logic              full
);
	import utf8d_pkg::*;

	logic [CP_W-1:0]  acc_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] taken_q;
	logic             inseq_q;

	logic [CP_W-1:0]  acc_d;
	logic [CNT_W-1:0] rem_d;
	logic [CNT_W-1:0] taken_d;
	logic             inseq_d;

	class_t           cls;
	res_t             idle_res;
	logic             idle_has;
	logic             idle_open;
	logic [CP_W-1:0]  shifted;
	logic [CNT_W-1:0] taken_inc;
	logic [CNT_W-1:0] rem_dec;
	logic             has0;
	logic             accept;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign push     = accept && has0;

	assign cls       = classify(byte_in);
	assign shifted   = {acc_q[CP_W-7:0], byte_in[5:0] & CONT_BITS};
	assign taken_inc = taken_q + 3'd1;
	assign rem_dec   = rem_q - 3'd1;

	// result of a byte seen with no sequence open
	always_comb begin
		idle_res.bytes_used = 3'd1;
		idle_res.run_last   = 1'b1;
		unique case (cls.kind)
			K_ASCII: begin
				idle_res.code_point = {23'b0, byte_in};
				idle_res.status     = ST_OK;
			end
			K_CONT: begin
				idle_res.code_point = {25'b0, byte_in[5:0] & CONT_BITS};
				idle_res.status     = ST_STRAY;
			end
			K_INVALID: begin
				idle_res.code_point = {23'b0, byte_in};
				idle_res.status     = ST_INVALID;
			end
			default: begin
				idle_res.code_point = {26'b0, cls.payload};
				idle_res.status     = ST_CUT_END;
			end
		endcase
		idle_has  = (cls.kind != K_LEAD) || buffer_end;
		idle_open = (cls.kind == K_LEAD) && !buffer_end;
	end

	always_comb begin
		acc_d      = acc_q;
		rem_d      = rem_q;
		taken_d    = taken_q;
		inseq_d    = inseq_q;
		has0       = 1'b0;
		push_entry = '0;
		if (inseq_q) begin
			if (cls.kind == K_CONT) begin
				push_entry.r0.code_point = shifted;
				push_entry.r0.bytes_used = taken_inc;
				push_entry.r0.run_last   = 1'b1;
				if (rem_dec == '0) begin
					push_entry.r0.status = ST_OK;
					has0    = 1'b1;
					inseq_d = 1'b0;
				end else if (buffer_end) begin
					push_entry.r0.status = ST_CUT_END;
					has0    = 1'b1;
					inseq_d = 1'b0;
				end else begin
					push_entry.r0.status = ST_OK;
					acc_d   = shifted;
					rem_d   = rem_dec;
					taken_d = taken_inc;
				end
			end else begin
				has0 = 1'b1;
				push_entry.r0.code_point = acc_q;
				push_entry.r0.bytes_used = taken_q;
				push_entry.r0.status     = ST_CUT_NC;
				push_entry.r0.run_last   = !idle_has;
				push_entry.r1  = idle_res;
				push_entry.two = idle_has;
				inseq_d = 1'b0;
				if (idle_open) begin
					acc_d   = {26'b0, cls.payload};
					rem_d   = cls.left;
					taken_d = 3'd1;
					inseq_d = 1'b1;
				end
			end
		end else begin
			has0 = idle_has;
			push_entry.r0 = idle_res;
			if (idle_open) begin
				acc_d   = {26'b0, cls.payload};
				rem_d   = cls.left;
				taken_d = 3'd1;
				inseq_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			rem_q   <= '0;
			taken_q <= '0;
			inseq_q <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			taken_q <= taken_d;
			inseq_q <= inseq_d;
		end
	end

	a_seq_counts: assert property (@(posedge clk) disable iff (!arst_n)
		inseq_q |-> (taken_q != '0) && (rem_q != '0))
		else $error("open sequence with empty counts");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		accept && buffer_end |=> !inseq_q)
		else $error("sequence left open after buffer end");

endmodule

@@ rtl/core/utf8d_queue.sv @@
// utf8d_queue: short register queue of result words between front and back
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_queue #(
	parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utf8d_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output utf8d_pkg::entry_t head
);
	import utf8d_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

@@ rtl/core/utf8d_back.sv @@
// utf8d_back: drains queue words one result at a time into the output register
// depends on utf8d_pkg; fed by utf8d_queue
`timescale 1ns / 1ps

module utf8d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  utf8d_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output utf8d_pkg::res_t out_res
);
	import utf8d_pkg::*;

	logic out_valid_q;
	res_t out_res_q;
	logic sel_q;
	logic load;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && (!head.two || sel_q);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= sel_q ? head.r1 : head.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= head.two && !sel_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_sel_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> head_valid && head.two)
		else $error("second result selected without a pair word");

	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && sel_q |=> out_res_q.run_last)
		else $error("second result not marked last");

endmodule
